>>> hdl/imh_pkg.sv
`timescale 1ns / 1ps

package imh_pkg;

    // fixed field widths
    localparam int VERTEX_W     = 6;
    localparam int VERTEX_COUNT = 64;
    localparam int KEY_W        = 31;
    localparam int COUNT_W      = 7;

    // request actions
    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_EXTRACT  = 2'd1,
        ACT_DECREASE = 2'd2,
        ACT_QUERY    = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_ABSENT = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        action_t               action;
        logic [VERTEX_W-1:0]   vertex_id;
        logic [KEY_W-1:0]      new_key;
    } req_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]   out_vertex;
        logic [KEY_W-1:0]      out_key;
        logic                  present;
        status_t               status;
        logic [COUNT_W-1:0]    entry_count;
    } rsp_t;

    // one heap slot
    typedef struct packed {
        logic [VERTEX_W-1:0]   vertex;
        logic [KEY_W-1:0]      key;
    } slot_entry_t;

endpackage

>>> hdl/imh_slot_ram.sv
`timescale 1ns / 1ps

module imh_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  imh_pkg::slot_entry_t      wr_data,
    input  logic [ADDR_W-1:0]         rd_addr_a,
    input  logic [ADDR_W-1:0]         rd_addr_b,
    output imh_pkg::slot_entry_t      rd_data_a,
    output imh_pkg::slot_entry_t      rd_data_b
);
    import imh_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_a_reg;
    slot_entry_t rd_b_reg;

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> hdl/indexed_min_heap_core.sv
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// request | start high, busy low | request: action, vertex_id, new_key
// result  | done, one cycle      | result: out_vertex, out_key, present, status,
//         |                      |         entry_count
//
// done rises once the request has run its course, and busy falls with it:
// a failed request ends at dispatch; query, duplicate insert, kept key or last entry
// end after one slot read; insert climbs level by level, decrease reads the key first;
// extract takes the root and the last entry, then descends level by level.
// reset clears the entry count and presence bits; slot and position memories need no clearing.
// the receiver cannot stall: done lasts one cycle and the next transfer may come with it.

module indexed_min_heap_core #(
    parameter int CAPACITY = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  imh_pkg::req_t  request,
    output logic           busy,
    output logic           done,
    output imh_pkg::rsp_t  result
);
    import imh_pkg::*;

    localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = SLOT_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_KEYED,
        S_EXT_TAKE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP
    } state_t;

    state_t                    state_reg, state_next;
    req_t                      req_reg, req_next;
    logic [CNT_W-1:0]          size_reg, size_next;
    logic [SLOT_W-1:0]         hole_reg, hole_next;
    slot_entry_t               move_reg, move_next;
    slot_entry_t               ext_reg, ext_next;
    logic [VERTEX_COUNT-1:0]   valid_reg, valid_next;
    logic                      done_reg, done_next;
    rsp_t                      result_reg, result_next;

    // slot store ports
    logic                      slot_wr_en;
    logic [SLOT_W-1:0]         slot_wr_addr;
    slot_entry_t               slot_wr_data;
    logic [SLOT_W-1:0]         rd_addr_a, rd_addr_b;
    slot_entry_t               rd_data_a, rd_data_b;

    // vertex position memory
    logic [SLOT_W-1:0]         pos_mem [VERTEX_COUNT];
    logic [SLOT_W-1:0]         pos_rd_reg;
    logic [VERTEX_W-1:0]       pos_rd_addr;
    logic                      pos_wr_en;
    logic [VERTEX_W-1:0]       pos_wr_addr;
    logic [SLOT_W-1:0]         pos_wr_data;

    // sift helpers
    logic                      present_v;
    logic [SLOT_W-1:0]         parent_idx;
    logic [CHILD_W-1:0]        child_l, child_r, size_ext;
    logic                      l_ok, r_ok, up_swap;
    logic [KEY_W-1:0]          best_key;

    function automatic rsp_t make_rsp(
        input logic [VERTEX_W-1:0] v,
        input logic [KEY_W-1:0]    k,
        input logic                p,
        input status_t             st,
        input logic [CNT_W-1:0]    cnt
    );
        rsp_t r;
        r.out_vertex  = v;
        r.out_key     = k;
        r.present     = p;
        r.status      = st;
        r.entry_count = COUNT_W'(cnt);
        return r;
    endfunction

    imh_slot_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .clk       (clk),
        .wr_en     (slot_wr_en),
        .wr_addr   (slot_wr_addr),
        .wr_data   (slot_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // position memory, registered read
    always_ff @(posedge clk)
    begin
        if (pos_wr_en)
        begin
            pos_mem[pos_wr_addr] <= pos_wr_data;
        end
        pos_rd_reg <= pos_mem[pos_rd_addr];
    end

    // shared key compare and index arithmetic
    assign present_v  = valid_reg[req_reg.vertex_id];
    assign parent_idx = (hole_reg - SLOT_W'(1)) >> 1;
    assign child_l    = {1'b0, hole_reg, 1'b1};
    assign child_r    = child_l + CHILD_W'(1);
    assign size_ext   = CHILD_W'(size_reg);
    assign up_swap    = rd_data_a.key > move_reg.key;
    assign l_ok       = (child_l < size_ext) && (move_reg.key > rd_data_a.key);
    assign best_key   = l_ok ? rd_data_a.key : move_reg.key;
    assign r_ok       = (child_r < size_ext) && (best_key > rd_data_b.key);

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        size_next    = size_reg;
        hole_next    = hole_reg;
        move_next    = move_reg;
        ext_next     = ext_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        slot_wr_en   = 1'b0;
        slot_wr_addr = hole_reg;
        slot_wr_data = move_reg;
        pos_wr_en    = 1'b0;
        pos_wr_addr  = move_reg.vertex;
        pos_wr_data  = hole_reg;
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        pos_rd_addr  = (state_reg == S_IDLE) ? request.vertex_id : req_reg.vertex_id;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (req_reg.action)
                    ACT_INSERT:
                    begin
                        if (present_v)
                        begin
                            rd_addr_a  = pos_rd_reg;
                            state_next = S_KEYED;
                        end
                        else if (size_reg >= CNT_W'(CAPACITY))
                        begin
                            done_next   = 1'b1;
                            result_next = make_rsp(req_reg.vertex_id, '0, 1'b0,
                                                   STATUS_FULL, size_reg);
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            move_next.vertex = req_reg.vertex_id;
                            move_next.key    = req_reg.new_key;
                            hole_next        = size_reg[SLOT_W-1:0];
                            size_next        = size_reg + CNT_W'(1);
                            valid_next[req_reg.vertex_id] = 1'b1;
                            state_next       = S_UP_RD;
                        end
                    end
                    ACT_EXTRACT:
                    begin
                        if (size_reg == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = make_rsp('0, '0, 1'b0, STATUS_EMPTY, size_reg);
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            rd_addr_a  = '0;
                            rd_addr_b  = SLOT_W'(size_reg - CNT_W'(1));
                            state_next = S_EXT_TAKE;
                        end
                    end
                    ACT_DECREASE, ACT_QUERY:
                    begin
                        if (!present_v)
                        begin
                            done_next   = 1'b1;
                            result_next = make_rsp(req_reg.vertex_id, '0, 1'b0,
                                                   STATUS_ABSENT, size_reg);
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            rd_addr_a  = pos_rd_reg;
                            state_next = S_KEYED;
                        end
                    end
                endcase
            end

            // current key of a present vertex is on read port a
            S_KEYED:
            begin
                if ((req_reg.action == ACT_DECREASE) && (req_reg.new_key <= rd_data_a.key))
                begin
                    move_next.vertex = req_reg.vertex_id;
                    move_next.key    = req_reg.new_key;
                    hole_next        = pos_rd_reg;
                    state_next       = S_UP_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = make_rsp(req_reg.vertex_id, rd_data_a.key, 1'b1,
                                           (req_reg.action == ACT_INSERT) ? STATUS_FULL
                                                                          : STATUS_OK,
                                           size_reg);
                    state_next  = S_IDLE;
                end
            end

            // root on port a, last entry on port b
            S_EXT_TAKE:
            begin
                ext_next  = rd_data_a;
                move_next = rd_data_b;
                hole_next = '0;
                size_next = size_reg - CNT_W'(1);
                valid_next[rd_data_a.vertex] = 1'b0;
                if (size_reg == CNT_W'(1))
                begin
                    done_next   = 1'b1;
                    result_next = make_rsp(rd_data_a.vertex, rd_data_a.key, 1'b0,
                                           STATUS_OK, size_next);
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_UP_RD:
            begin
                if (hole_reg == '0)
                begin
                    slot_wr_en  = 1'b1;
                    pos_wr_en   = 1'b1;
                    done_next   = 1'b1;
                    result_next = make_rsp(req_reg.vertex_id, req_reg.new_key, 1'b1,
                                           STATUS_OK, size_reg);
                    state_next  = S_IDLE;
                end
                else
                begin
                    rd_addr_a  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            // parent moves down into the hole, or the entry settles
            S_UP_CMP:
            begin
                slot_wr_en = 1'b1;
                pos_wr_en  = 1'b1;
                if (up_swap)
                begin
                    slot_wr_data = rd_data_a;
                    pos_wr_addr  = rd_data_a.vertex;
                    hole_next    = parent_idx;
                    state_next   = S_UP_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = make_rsp(req_reg.vertex_id, req_reg.new_key, 1'b1,
                                           STATUS_OK, size_reg);
                    state_next  = S_IDLE;
                end
            end

            S_DN_RD:
            begin
                rd_addr_a  = child_l[SLOT_W-1:0];
                rd_addr_b  = child_r[SLOT_W-1:0];
                state_next = S_DN_CMP;
            end

            // smaller child moves up into the hole, or the entry settles
            S_DN_CMP:
            begin
                slot_wr_en = 1'b1;
                pos_wr_en  = 1'b1;
                if (r_ok)
                begin
                    slot_wr_data = rd_data_b;
                    pos_wr_addr  = rd_data_b.vertex;
                    hole_next    = child_r[SLOT_W-1:0];
                    state_next   = S_DN_RD;
                end
                else if (l_ok)
                begin
                    slot_wr_data = rd_data_a;
                    pos_wr_addr  = rd_data_a.vertex;
                    hole_next    = child_l[SLOT_W-1:0];
                    state_next   = S_DN_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = make_rsp(ext_reg.vertex, ext_reg.key, 1'b0,
                                           STATUS_OK, size_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        hole_reg   <= hole_next;
        move_reg   <= move_next;
        ext_reg    <= ext_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> dv/indexed_min_heap_core_tb.sv
`timescale 1ns / 1ps

module indexed_min_heap_core_tb;

    import imh_pkg::*;

    localparam int CAP          = 64;
    localparam int NO_SLOT      = 127;
    localparam int TOTAL_ITEMS  = 1200;
    localparam int CALM_ITEMS   = 150;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    // mirror of the heap, predicts each result and checks what comes back
    class heap_scoreboard;
        bit [VERTEX_W-1:0] slot_vtx[CAP];
        bit [KEY_W-1:0]    slot_key[CAP];
        int                slot_of[VERTEX_COUNT];
        int                entries;
        rsp_t              expected_q[$];
        int                failures;
        int                checked;
        int                action_seen[4];
        int                status_seen[4];
        int                full_hits;

        function new();
            entries  = 0;
            failures = 0;
            checked  = 0;
            full_hits = 0;
            foreach (slot_of[i])
                slot_of[i] = NO_SLOT;
            foreach (action_seen[i])
            begin
                action_seen[i] = 0;
                status_seen[i] = 0;
            end
        endfunction

        function bit holds(int v);
            return slot_of[v] < entries;
        endfunction

        function bit [KEY_W-1:0] key_of(int v);
            return slot_key[slot_of[v]];
        endfunction

        function void swap_slots(int a, int b);
            bit [VERTEX_W-1:0] va;
            bit [VERTEX_W-1:0] vb;
            bit [KEY_W-1:0] k;
            va = slot_vtx[a];
            vb = slot_vtx[b];
            k  = slot_key[a];
            slot_vtx[a] = vb;
            slot_vtx[b] = va;
            slot_key[a] = slot_key[b];
            slot_key[b] = k;
            slot_of[va] = b;
            slot_of[vb] = a;
        endfunction

        // strict compare, so equal keys stay where they are
        function void climb(int i);
            while (i != 0 && slot_key[(i - 1) / 2] > slot_key[i])
            begin
                swap_slots(i, (i - 1) / 2);
                i = (i - 1) / 2;
            end
        endfunction

        function void sink(int i);
            int l;
            int r;
            int m;
            forever
            begin
                l = 2 * i + 1;
                r = 2 * i + 2;
                m = i;
                if (l < entries && slot_key[m] > slot_key[l])
                    m = l;
                if (r < entries && slot_key[m] > slot_key[r])
                    m = r;
                if (m == i)
                    return;
                swap_slots(i, m);
                i = m;
            end
        endfunction

        // work out the result of one accepted request transfer
        function void note_request(req_t req);
            rsp_t want;
            int   v;
            int   p;
            v = int'(req.vertex_id);
            want.out_vertex = req.vertex_id;
            want.out_key    = '0;
            want.present    = 1'b0;
            want.status     = STATUS_OK;
            action_seen[int'(req.action)]++;
            case (req.action)
                ACT_INSERT:
                begin
                    if (holds(v) || entries >= CAP)
                        want.status = STATUS_FULL;
                    else
                    begin
                        slot_vtx[entries] = req.vertex_id;
                        slot_key[entries] = req.new_key;
                        slot_of[v] = entries;
                        entries++;
                        climb(entries - 1);
                        if (entries == CAP)
                            full_hits++;
                    end
                end
                ACT_EXTRACT:
                begin
                    if (entries == 0)
                    begin
                        want.status     = STATUS_EMPTY;
                        want.out_vertex = '0;
                    end
                    else
                    begin
                        want.out_vertex = slot_vtx[0];
                        want.out_key    = slot_key[0];
                        swap_slots(0, entries - 1);
                        entries--;
                        slot_of[want.out_vertex] = NO_SLOT;
                        sink(0);
                    end
                end
                ACT_DECREASE:
                begin
                    if (!holds(v))
                        want.status = STATUS_ABSENT;
                    else
                    begin
                        // a key increase is dropped silently
                        p = slot_of[v];
                        if (req.new_key <= slot_key[p])
                        begin
                            slot_key[p] = req.new_key;
                            climb(p);
                        end
                    end
                end
                default:
                begin
                    if (!holds(v))
                        want.status = STATUS_ABSENT;
                end
            endcase
            if (req.action != ACT_EXTRACT && holds(v))
            begin
                want.present = 1'b1;
                want.out_key = key_of(v);
            end
            want.entry_count = COUNT_W'(entries);
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        // compare one result transfer against the oldest prediction
        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding: vertex %0d status %0d",
                       got.out_vertex, got.status);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_seen[int'(got.status)]++;
            compare_field("out_vertex", 32'(want.out_vertex), 32'(got.out_vertex));
            compare_field("out_key", 32'(want.out_key), 32'(got.out_key));
            compare_field("present", 32'(want.present), 32'(got.present));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    req_t  request;
    logic  busy;
    logic  done;
    rsp_t  result;

    heap_scoreboard tracker = new();
    int  sent;
    bit  gaps_on;

    indexed_min_heap_core #(
        .CAPACITY (CAP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result monitor, sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(result);
    end

    function automatic req_t make_req(action_t a, int v, logic [KEY_W-1:0] k);
        req_t r;
        r.action    = a;
        r.vertex_id = VERTEX_W'(v);
        r.new_key   = k;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] draw_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return KEY_MAX;
            2, 3, 4: return KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // a vertex that is in the heap, or not, when one exists
    function automatic int pick_vertex(bit want_in);
        int pool[$];
        for (int v = 0; v < VERTEX_COUNT; v++)
        begin
            if (tracker.holds(v) == want_in)
                pool.push_back(v);
        end
        if (pool.size() == 0)
            return $urandom_range(0, VERTEX_COUNT - 1);
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // idle burst: start low, payload left as noise
    task automatic hold_off(int n);
        logic [63:0] noise;
        repeat (n)
        begin
            @(negedge clk);
            noise = {$urandom, $urandom};
            start   <= 1'b0;
            request <= noise[$bits(req_t)-1:0];
        end
    endtask

    // present one request and wait for its transfer
    task automatic send(req_t req);
        if (gaps_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 11));
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        tracker.note_request(req);
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // one random request; mode 0 grows the heap, 1 shrinks it, 2 is balanced
    task automatic random_item(int mode);
        int     roll;
        int     v;
        bit     aimed;
        action_t a;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] cur;
        roll  = $urandom_range(0, 99);
        aimed = $urandom_range(0, 99) < 85;
        case (mode)
            0:       a = roll < 55 ? ACT_INSERT : roll < 70 ? ACT_EXTRACT :
                         roll < 90 ? ACT_DECREASE : ACT_QUERY;
            1:       a = roll < 15 ? ACT_INSERT : roll < 70 ? ACT_EXTRACT :
                         roll < 85 ? ACT_DECREASE : ACT_QUERY;
            default: a = roll < 30 ? ACT_INSERT : roll < 60 ? ACT_EXTRACT :
                         roll < 85 ? ACT_DECREASE : ACT_QUERY;
        endcase
        if (aimed)
            v = pick_vertex(a != ACT_INSERT);
        else
            v = $urandom_range(0, VERTEX_COUNT - 1);
        k = draw_key();
        if (a == ACT_DECREASE && tracker.holds(v))
        begin
            cur  = tracker.key_of(v);
            roll = $urandom_range(0, 9);
            if (roll < 6)
                k = KEY_W'($urandom_range(0, cur));
            else if (roll < 8)
                k = cur;
        end
        send(make_req(a, v, k));
    endtask

    initial
    begin
        int order[VERTEX_COUNT];
        int j;
        int t;
        int mode;
        int chunk;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        sent    = 0;
        gaps_on = 1'b1;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty heap, absent vertices, key extremes, ties, duplicates
        send(make_req(ACT_EXTRACT, 17, '0));
        send(make_req(ACT_QUERY, 5, '0));
        send(make_req(ACT_DECREASE, 5, 31'd3));
        send(make_req(ACT_INSERT, 63, KEY_MAX));
        send(make_req(ACT_INSERT, 0, '0));
        send(make_req(ACT_INSERT, 42, '0));
        send(make_req(ACT_INSERT, 0, 31'd5));
        send(make_req(ACT_QUERY, 63, '0));
        send(make_req(ACT_DECREASE, 63, KEY_MAX));
        send(make_req(ACT_DECREASE, 42, 31'd100));
        send(make_req(ACT_DECREASE, 63, '0));
        send(make_req(ACT_INSERT, 21, 31'h2AAA_AAAA));
        send(make_req(ACT_INSERT, 1, 31'h5555_5555));
        send(make_req(ACT_DECREASE, 1, 31'd1));
        send(make_req(ACT_QUERY, 42, '0));
        send(make_req(ACT_EXTRACT, 0, KEY_MAX));
        send(make_req(ACT_QUERY, 0, '0));
        send(make_req(ACT_EXTRACT, 0, '0));
        send(make_req(ACT_EXTRACT, 0, '0));
        send(make_req(ACT_EXTRACT, 0, '0));
        send(make_req(ACT_EXTRACT, 0, '0));
        send(make_req(ACT_EXTRACT, 0, '0));
        send(make_req(ACT_DECREASE, 21, '0));

        // sender holds back until the pipeline has emptied
        wait_drained();

        // fill to capacity in shuffled order, poke the full heap, then drain it
        foreach (order[i])
            order[i] = i;
        for (int i = VERTEX_COUNT - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i])
            send(make_req(ACT_INSERT, order[i], draw_key()));
        repeat (4)
            send(make_req(ACT_INSERT, $urandom_range(0, VERTEX_COUNT - 1), draw_key()));
        repeat (10)
            random_item(2);
        while (tracker.entries < CAP)
            send(make_req(ACT_INSERT, pick_vertex(1'b0), draw_key()));
        repeat (CAP + 1)
            send(make_req(ACT_EXTRACT, $urandom_range(0, VERTEX_COUNT - 1), draw_key()));

        // random episodes that swing the heap between empty and full
        while (sent < TOTAL_ITEMS - CALM_ITEMS)
        begin
            mode  = $urandom_range(0, 2);
            chunk = $urandom_range(20, 80);
            repeat (chunk)
                random_item(mode);
        end

        // closing stretch at full rate
        gaps_on = 1'b0;
        while (sent < TOTAL_ITEMS)
            random_item(2);

        wait_drained();
        repeat (40)
            @(posedge clk);

        $display("%0d results checked: insert %0d, extract %0d, decrease %0d, query %0d",
                 tracker.checked, tracker.action_seen[ACT_INSERT],
                 tracker.action_seen[ACT_EXTRACT], tracker.action_seen[ACT_DECREASE],
                 tracker.action_seen[ACT_QUERY]);
        $display("status ok %0d, empty %0d, absent %0d, full/duplicate %0d; heap full %0d times",
                 tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_EMPTY],
                 tracker.status_seen[STATUS_ABSENT], tracker.status_seen[STATUS_FULL],
                 tracker.full_hits);
        if (tracker.failures == 0 && tracker.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/imh_pkg.sv
hdl/imh_slot_ram.sv
hdl/indexed_min_heap_core.sv
dv/indexed_min_heap_core_tb.sv
